// ----- rtl/tser_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tser_pkg
// Types, register indexes and constant tables of the two-strain epidemic
// right-hand-side core.
// ============================================================================
package tser_pkg;

    localparam int COS_TABLE_DEPTH = 1024;
    localparam int FRAC_BITS       = 30;

    localparam int COS_LOG2    = $clog2(COS_TABLE_DEPTH);
    localparam int COS_QUARTER = COS_TABLE_DEPTH / 4;
    localparam int COS_IDX_W   = COS_LOG2 - 1;

    localparam int FRAC_W = 31;
    localparam int OUT_W  = 48;
    localparam int LAM_W  = 46;
    localparam int LAM_LO = 24;
    localparam int FLOW_W = 57;
    localparam int LIN_W  = 43;
    localparam int SUM_W  = 62;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [16:0] SHARE_ONE   = 17'd65536;

    localparam logic [7:0] TAYLOR_DIV [8] = '{8'd2, 8'd12, 8'd30, 8'd56,
                                              8'd90, 8'd132, 8'd182, 8'd240};

    typedef enum logic [7:0] {
        CFG_BIRTH_DEATH = 8'd0,
        CFG_CONTACT_ONE = 8'd1,
        CFG_CONTACT_TWO = 8'd2,
        CFG_RECOVERY    = 8'd3,
        CFG_CROSS_SHARE = 8'd4,
        CFG_FORCING_AMP = 8'd5,
        CFG_IMPORT_ONE  = 8'd6,
        CFG_IMPORT_TWO  = 8'd7
    } t_cfg_index;

    typedef struct packed {
        logic [15:0]       year_phase;
        logic [FRAC_W-1:0] susceptible;
        logic [FRAC_W-1:0] immune_one;
        logic [FRAC_W-1:0] immune_two;
        logic [FRAC_W-1:0] immune_both;
        logic [FRAC_W-1:0] infected_one;
        logic [FRAC_W-1:0] infected_two;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] d_susceptible;
        logic signed [OUT_W-1:0] d_immune_one;
        logic signed [OUT_W-1:0] d_immune_two;
        logic signed [OUT_W-1:0] d_immune_both;
        logic signed [OUT_W-1:0] d_infected_one;
        logic signed [OUT_W-1:0] d_infected_two;
    } t_out_item;

    typedef logic [30:0] t_cos_table [COS_QUARTER+1];

    // first-quadrant cosine magnitude, truncating Taylor series in Q1.30
    function automatic logic [30:0] cos_mag_of(int unsigned j);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] mag;
        r    = 64'(j) << (32 - COS_LOG2);
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        pos  = '0;
        neg  = '0;
        for (int n = 0; n < 8; n++) begin
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
        end
        mag = (pos > neg) ? pos - neg : 64'd0;
        if (mag > ONE_Q30) begin
            mag = ONE_Q30;
        end
        return 31'(mag);
    endfunction

    function automatic t_cos_table build_cos_table();
        t_cos_table t;
        for (int j = 0; j <= COS_QUARTER; j++) begin
            t[j] = cos_mag_of(j);
        end
        return t;
    endfunction

    localparam t_cos_table COS_TABLE = build_cos_table();

    // birth term: u moved from 20 to FRAC_BITS fractional bits
    function automatic logic [SUM_W-1:0] birth_term(logic [31:0] u);
        logic [SUM_W-1:0] w;
        w = SUM_W'(u);
        if (FRAC_BITS >= 20) begin
            return w << (FRAC_BITS - 20);
        end else begin
            return w >> (20 - FRAC_BITS);
        end
    endfunction

endpackage

// ----- rtl/two_strain_epidemic_rhs_core.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle; the nine-stage pipeline holds as a whole
// while a result waits at the output.
// Reset (synchronous, active low) clears all stage valid bits and sets
// every configuration register to zero.
// ============================================================================
// two_strain_epidemic_rhs_core
// Seasonally forced two-strain epidemic derivative evaluator, fixed point,
// nine register stages: cosine, forcing, rates, forces, products, flows,
// shares, sums, saturation.
// ============================================================================
module two_strain_epidemic_rhs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tser_pkg::t_in_item i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output tser_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import tser_pkg::*;

    localparam int NUM_ST = 9;

    // configuration
    logic [31:0] r_cfg_u, r_cfg_b1, r_cfg_b2, r_cfg_v;
    logic [16:0] r_cfg_s, r_cfg_e;
    logic [29:0] r_cfg_m1, r_cfg_m2;
    logic [16:0] s_eff, e_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_u  <= '0;
            r_cfg_b1 <= '0;
            r_cfg_b2 <= '0;
            r_cfg_v  <= '0;
            r_cfg_s  <= '0;
            r_cfg_e  <= '0;
            r_cfg_m1 <= '0;
            r_cfg_m2 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BIRTH_DEATH: r_cfg_u  <= i_cfg_data;
                CFG_CONTACT_ONE: r_cfg_b1 <= i_cfg_data;
                CFG_CONTACT_TWO: r_cfg_b2 <= i_cfg_data;
                CFG_RECOVERY:    r_cfg_v  <= i_cfg_data;
                CFG_CROSS_SHARE: r_cfg_s  <= i_cfg_data[16:0];
                CFG_FORCING_AMP: r_cfg_e  <= i_cfg_data[16:0];
                CFG_IMPORT_ONE:  r_cfg_m1 <= i_cfg_data[29:0];
                CFG_IMPORT_TWO:  r_cfg_m2 <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    assign s_eff = (r_cfg_s > SHARE_ONE) ? SHARE_ONE : r_cfg_s;
    assign e_eff = (r_cfg_e > SHARE_ONE) ? SHARE_ONE : r_cfg_e;

    // pipeline control
    logic [NUM_ST-1:0] r_vld;
    logic              en;

    assign en      = !r_vld[NUM_ST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NUM_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_ST-2:0], i_valid};
        end
    end

    // stage 1: cosine table
    logic [COS_LOG2-1:0]  k;
    logic [COS_IDX_W-1:0] cos_idx;
    logic [30:0]          r1_mag;
    logic                 r1_neg;
    t_in_item             r1_item;

    assign k       = i_data.year_phase[15 -: COS_LOG2];
    assign cos_idx = k[COS_LOG2-2] ? COS_IDX_W'(COS_QUARTER) - COS_IDX_W'(k[COS_LOG2-3:0])
                                   : COS_IDX_W'(k[COS_LOG2-3:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag  <= COS_TABLE[cos_idx];
            r1_neg  <= k[COS_LOG2-1] ^ k[COS_LOG2-2];
            r1_item <= i_data;
        end
    end

    // stage 2: forcing factor and force sums
    logic [47:0] ec_prod;
    logic [31:0] ec;
    logic [31:0] r2_f, r2_im1, r2_im2;
    t_in_item    r2_item;

    assign ec_prod = 48'(r1_mag) * 48'(e_eff);
    assign ec      = 32'(ec_prod >> 16);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_f    <= r1_neg ? 32'(ONE_Q30) - ec : 32'(ONE_Q30) + ec;
            r2_im1  <= 32'(r1_item.infected_one) + 32'(r_cfg_m1);
            r2_im2  <= 32'(r1_item.infected_two) + 32'(r_cfg_m2);
            r2_item <= r1_item;
        end
    end

    // stage 3: forced contact rates
    logic [63:0] b1_prod, b2_prod;
    logic [33:0] r3_b1, r3_b2;
    logic [31:0] r3_im1, r3_im2;
    t_in_item    r3_item;

    assign b1_prod = 64'(r2_f) * 64'(r_cfg_b1);
    assign b2_prod = 64'(r2_f) * 64'(r_cfg_b2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_b1   <= b1_prod[63:30];
            r3_b2   <= b2_prod[63:30];
            r3_im1  <= r2_im1;
            r3_im2  <= r2_im2;
            r3_item <= r2_item;
        end
    end

    // stage 4: forces of infection
    logic [65:0]      l1_prod, l2_prod;
    logic [LAM_W-1:0] r4_lam1, r4_lam2;
    t_in_item         r4_item;

    assign l1_prod = 66'(r3_b1) * 66'(r3_im1);
    assign l2_prod = 66'(r3_b2) * 66'(r3_im2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_lam1 <= l1_prod[65:20];
            r4_lam2 <= l2_prod[65:20];
            r4_item <= r3_item;
        end
    end

    // stage 5: split flow products and linear terms
    // flows: a1, a2, r1s, c2, r2s, e1
    // linear: uS, uR1, uR2, uR12, uI1, vI1, uI2, vI2
    logic [LAM_W-1:0]  fl_lam [6];
    logic [FRAC_W-1:0] fl_y   [6];
    logic [31:0]       ln_rate [8];
    logic [FRAC_W-1:0] ln_y    [8];
    logic [54:0]       r5_pl [6];
    logic [52:0]       r5_ph [6];
    logic [LIN_W-1:0]  r5_lin [8];
    logic [62:0]       ln_prod [8];

    always_comb begin
        fl_lam[0] = r4_lam1; fl_y[0] = r4_item.susceptible;
        fl_lam[1] = r4_lam2; fl_y[1] = r4_item.susceptible;
        fl_lam[2] = r4_lam1; fl_y[2] = r4_item.immune_one;
        fl_lam[3] = r4_lam2; fl_y[3] = r4_item.immune_one;
        fl_lam[4] = r4_lam2; fl_y[4] = r4_item.immune_two;
        fl_lam[5] = r4_lam1; fl_y[5] = r4_item.immune_two;
        ln_rate[0] = r_cfg_u; ln_y[0] = r4_item.susceptible;
        ln_rate[1] = r_cfg_u; ln_y[1] = r4_item.immune_one;
        ln_rate[2] = r_cfg_u; ln_y[2] = r4_item.immune_two;
        ln_rate[3] = r_cfg_u; ln_y[3] = r4_item.immune_both;
        ln_rate[4] = r_cfg_u; ln_y[4] = r4_item.infected_one;
        ln_rate[5] = r_cfg_v; ln_y[5] = r4_item.infected_one;
        ln_rate[6] = r_cfg_u; ln_y[6] = r4_item.infected_two;
        ln_rate[7] = r_cfg_v; ln_y[7] = r4_item.infected_two;
        for (int i = 0; i < 8; i++) begin
            ln_prod[i] = 63'(ln_rate[i]) * 63'(ln_y[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r5_pl[i] <= 55'(fl_lam[i][LAM_LO-1:0]) * 55'(fl_y[i]);
                r5_ph[i] <= 53'(fl_lam[i][LAM_W-1:LAM_LO]) * 53'(fl_y[i]);
            end
            for (int i = 0; i < 8; i++) begin
                r5_lin[i] <= ln_prod[i][62:20];
            end
        end
    end

    // stage 6: flows, capped at 2^56
    logic [77:0]       fl_full [6];
    logic [77:0]       fl_shr  [6];
    logic [FLOW_W-1:0] r6_flow [6];
    logic [LIN_W-1:0]  r6_lin  [8];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            fl_full[i] = 78'({r5_ph[i], {LAM_LO{1'b0}}}) + 78'(r5_pl[i]);
            fl_shr[i]  = fl_full[i] >> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r6_flow[i] <= (fl_shr[i] > (78'd1 << 56)) ? (FLOW_W'(1) << 56)
                                                           : FLOW_W'(fl_shr[i]);
            end
            r6_lin <= r5_lin;
        end
    end

    // stage 7: cross-immunity shares of a1, a2, r1s, r2s
    logic [FLOW_W-1:0] sh_x [4];
    logic [57:0]       sh_hi [4];
    logic [32:0]       sh_lo [4];
    logic [FLOW_W-1:0] r7_flow  [6];
    logic [FLOW_W-1:0] r7_share [4];
    logic [LIN_W-1:0]  r7_lin   [8];

    always_comb begin
        sh_x[0] = r6_flow[0];
        sh_x[1] = r6_flow[1];
        sh_x[2] = r6_flow[2];
        sh_x[3] = r6_flow[4];
        for (int i = 0; i < 4; i++) begin
            sh_hi[i] = 58'(sh_x[i][FLOW_W-1:16]) * 58'(s_eff);
            sh_lo[i] = 33'(sh_x[i][15:0]) * 33'(s_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r7_share[i] <= FLOW_W'(sh_hi[i] + 58'(sh_lo[i][32:16]));
            end
            r7_flow <= r6_flow;
            r7_lin  <= r6_lin;
        end
    end

    // stage 8: derivative sums
    logic signed [SUM_W-1:0] fa1, fa2, fr1, fc2, fr2, fe1;
    logic signed [SUM_W-1:0] sa1, sa2, sr1, sr2;
    logic signed [SUM_W-1:0] lin [8];
    logic signed [SUM_W-1:0] birth;
    logic signed [SUM_W-1:0] r8_d [6];

    always_comb begin
        fa1 = $signed(SUM_W'(r7_flow[0]));
        fa2 = $signed(SUM_W'(r7_flow[1]));
        fr1 = $signed(SUM_W'(r7_flow[2]));
        fc2 = $signed(SUM_W'(r7_flow[3]));
        fr2 = $signed(SUM_W'(r7_flow[4]));
        fe1 = $signed(SUM_W'(r7_flow[5]));
        sa1 = $signed(SUM_W'(r7_share[0]));
        sa2 = $signed(SUM_W'(r7_share[1]));
        sr1 = $signed(SUM_W'(r7_share[2]));
        sr2 = $signed(SUM_W'(r7_share[3]));
        for (int i = 0; i < 8; i++) begin
            lin[i] = $signed(SUM_W'(r7_lin[i]));
        end
        birth = $signed(birth_term(r_cfg_u));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_d[0] <= birth - fa1 - fa2 - lin[0];
            r8_d[1] <= (fa1 - sa1) - sr1 - fc2 - lin[1];
            r8_d[2] <= (fa2 - sa2) - sr2 - fe1 - lin[2];
            r8_d[3] <= sa1 + sa2 + sr1 + sr2 + fc2 + fe1 - lin[3];
            r8_d[4] <= fa1 + fe1 - lin[5] - lin[4];
            r8_d[5] <= fa2 + fc2 - lin[7] - lin[6];
        end
    end

    // stage 9: saturation into the output register
    localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) << (OUT_W - 1));

    function automatic logic signed [OUT_W-1:0] sat_out(logic signed [SUM_W-1:0] d);
        if (d > OUT_MAX) begin
            return OUT_MAX[OUT_W-1:0];
        end else if (d < OUT_MIN) begin
            return OUT_MIN[OUT_W-1:0];
        end else begin
            return d[OUT_W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.d_susceptible  <= sat_out(r8_d[0]);
            o_data.d_immune_one   <= sat_out(r8_d[1]);
            o_data.d_immune_two   <= sat_out(r8_d[2]);
            o_data.d_immune_both  <= sat_out(r8_d[3]);
            o_data.d_infected_one <= sat_out(r8_d[4]);
            o_data.d_infected_two <= sat_out(r8_d[5]);
        end
    end

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_vld == $past(r_vld))
        else $error("pipeline valid bits moved during stall");
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r1_mag <= 31'(ONE_Q30))
        else $error("cosine magnitude above one");
    a_forcing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> r2_f <= 32'(ONE_Q30 << 1))
        else $error("forcing factor out of range");
    a_share_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r7_share[0] <= r7_flow[0] && r7_share[1] <= r7_flow[1]))
        else $error("cross share exceeds its flow");
`endif

endmodule

// ----- sim/two_strain_epidemic_rhs_core_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// two_strain_epidemic_rhs_core_test
// Self-checking bench for the two-strain epidemic derivative core. A queue of
// compartment states feeds a clocked driver; each transfer is predicted with a
// fixed-point model of the seasonal forcing, rates and flows, and a monitor
// compares every output transfer field by field. Register settings change
// between phases while the core is idle; both sides idle at random.
// ============================================================================
module two_strain_epidemic_rhs_core_test;
    import tser_pkg::*;

    localparam logic [7:0] UNUSED_INDEX = 8'd8;
    localparam logic [7:0] TOP_INDEX    = 8'd255;
    localparam int         LATENCY      = 9;
    localparam int         CYCLE_LIMIT  = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_data;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    two_strain_epidemic_rhs_core dut (.*);

    t_in_item    state_queue[$];
    t_out_item   deriv_queue[$];
    logic [31:0] regs_model[8];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;
    int          hold_left;
    bit          in_taken;
    int          errors;
    int          cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit [63:0] scaled_mul(bit [63:0] a, bit [63:0] b, int sh);
        bit [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod >> sh);
    endfunction

    function automatic bit [63:0] share_part(bit [63:0] x, bit [63:0] s);
        return (x >> 16) * s + (((x & 64'hFFFF) * s) >> 16);
    endfunction

    function automatic bit [63:0] flow_cap(bit [63:0] x);
        return (x > (64'd1 << 56)) ? (64'd1 << 56) : x;
    endfunction

    function automatic logic [47:0] sat48(longint v);
        if (v > ((longint'(1) << 47) - 1)) v = (longint'(1) << 47) - 1;
        if (v < -(longint'(1) << 47)) v = -(longint'(1) << 47);
        return v[47:0];
    endfunction

    // cosine of a Q0.32 turn, signed Q2.30
    function automatic longint seasonal_cos(bit [63:0] turn);
        bit [1:0]  quad;
        bit [63:0] r, x, x2, term, pos, neg, mag;
        quad = turn[31:30];
        r    = turn & ((64'd1 << 30) - 1);
        if (quad[0]) r = (64'd1 << 30) - r;
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        pos  = 0;
        neg  = 0;
        for (int n = 0; n < 8; n++) begin
            if (n % 2 == 1) neg += term;
            else pos += term;
            term = ((term * x2) >> 30) / 64'((2 * n + 1) * (2 * n + 2));
        end
        mag = (pos > neg) ? pos - neg : 64'd0;
        if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
        return (quad == 2'd1 || quad == 2'd2) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic t_out_item predict_derivs(t_in_item it);
        bit [63:0] u, b1, b2, v, s, e, m1, m2;
        bit [63:0] sus, r1, r2, r12, i1, i2;
        bit [63:0] k, turn, ec, force_q30, rate1, rate2, lam1, lam2;
        bit [63:0] a1, a2, r1s, c2, r2s, e1, birth;
        longint    c;
        t_out_item res;
        u   = regs_model[CFG_BIRTH_DEATH];
        b1  = regs_model[CFG_CONTACT_ONE];
        b2  = regs_model[CFG_CONTACT_TWO];
        v   = regs_model[CFG_RECOVERY];
        s   = (regs_model[CFG_CROSS_SHARE] > 65536) ? 64'd65536 : regs_model[CFG_CROSS_SHARE];
        e   = (regs_model[CFG_FORCING_AMP] > 65536) ? 64'd65536 : regs_model[CFG_FORCING_AMP];
        m1  = regs_model[CFG_IMPORT_ONE];
        m2  = regs_model[CFG_IMPORT_TWO];
        sus = it.susceptible;
        r1  = it.immune_one;
        r2  = it.immune_two;
        r12 = it.immune_both;
        i1  = it.infected_one;
        i2  = it.infected_two;

        k    = (64'(it.year_phase) * COS_TABLE_DEPTH) >> 16;
        turn = (k << 32) / COS_TABLE_DEPTH;
        c    = seasonal_cos(turn);
        ec   = (e * 64'((c < 0) ? -c : c)) >> 16;
        force_q30 = (c < 0) ? (64'd1 << 30) - ec : (64'd1 << 30) + ec;

        rate1 = scaled_mul(force_q30, b1, 30);
        rate2 = scaled_mul(force_q30, b2, 30);
        lam1  = scaled_mul(rate1, i1 + m1, 20);
        lam2  = scaled_mul(rate2, i2 + m2, 20);

        a1  = flow_cap(scaled_mul(lam1, sus, FRAC_BITS));
        a2  = flow_cap(scaled_mul(lam2, sus, FRAC_BITS));
        r1s = flow_cap(scaled_mul(lam1, r1, FRAC_BITS));
        c2  = flow_cap(scaled_mul(lam2, r1, FRAC_BITS));
        r2s = flow_cap(scaled_mul(lam2, r2, FRAC_BITS));
        e1  = flow_cap(scaled_mul(lam1, r2, FRAC_BITS));
        birth = u << (FRAC_BITS - 20);

        res.d_susceptible = sat48(longint'(birth) - longint'(a1) - longint'(a2)
                                  - longint'(scaled_mul(u, sus, 20)));
        res.d_immune_one = sat48(longint'(a1 - share_part(a1, s))
                                 - longint'(share_part(r1s, s)) - longint'(c2)
                                 - longint'(scaled_mul(u, r1, 20)));
        res.d_immune_two = sat48(longint'(a2 - share_part(a2, s))
                                 - longint'(share_part(r2s, s)) - longint'(e1)
                                 - longint'(scaled_mul(u, r2, 20)));
        res.d_immune_both = sat48(longint'(share_part(a1, s)) + longint'(share_part(a2, s))
                                  + longint'(share_part(r1s, s))
                                  + longint'(share_part(r2s, s))
                                  + longint'(c2) + longint'(e1)
                                  - longint'(scaled_mul(u, r12, 20)));
        res.d_infected_one = sat48(longint'(a1) + longint'(e1)
                                   - longint'(scaled_mul(v, i1, 20))
                                   - longint'(scaled_mul(u, i1, 20)));
        res.d_infected_two = sat48(longint'(a2) + longint'(c2)
                                   - longint'(scaled_mul(v, i2, 20))
                                   - longint'(scaled_mul(u, i2, 20)));
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (state_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_data  <= state_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver with long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        logic [47:0] w, a;
        cycles   = cycles + 1;
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) deriv_queue.push_back(predict_derivs(i_data));
        if (i_rst_n && o_valid && i_ready) begin
            if (deriv_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_data);
            end else begin
                want = deriv_queue.pop_front();
                for (int f = 0; f < 6; f++) begin
                    w = want[(5 - f) * 48 +: 48];
                    a = o_data[(5 - f) * 48 +: 48];
                    if (w !== a) begin
                        errors++;
                        $display("%0t: field %0d expected %h actual %h", $time, f, w, a);
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("two_strain_epidemic_rhs_core verification failed");
            $finish;
        end
    end

    task automatic reg_write(logic [7:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BIRTH_DEATH, CFG_CONTACT_ONE, CFG_CONTACT_TWO, CFG_RECOVERY:
                regs_model[idx] = val;
            CFG_CROSS_SHARE, CFG_FORCING_AMP:
                regs_model[idx] = val & 32'h1FFFF;
            CFG_IMPORT_ONE, CFG_IMPORT_TWO:
                regs_model[idx] = val & 32'h3FFFFFFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] u, logic [31:0] b1, logic [31:0] b2, logic [31:0] v,
                           logic [31:0] s, logic [31:0] e, logic [31:0] m1, logic [31:0] m2);
        reg_write(CFG_BIRTH_DEATH, u);
        reg_write(CFG_CONTACT_ONE, b1);
        reg_write(CFG_CONTACT_TWO, b2);
        reg_write(CFG_RECOVERY, v);
        reg_write(CFG_CROSS_SHARE, s);
        reg_write(CFG_FORCING_AMP, e);
        reg_write(CFG_IMPORT_ONE, m1);
        reg_write(CFG_IMPORT_TWO, m2);
    endtask

    task automatic wait_idle();
        wait (state_queue.size() == 0 && !i_valid && deriv_queue.size() == 0);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic push_state(logic [15:0] ph, logic [30:0] sv, logic [30:0] r1v,
                              logic [30:0] r2v, logic [30:0] r12v, logic [30:0] i1v,
                              logic [30:0] i2v);
        t_in_item it;
        it.year_phase   = ph;
        it.susceptible  = sv;
        it.immune_one   = r1v;
        it.immune_two   = r2v;
        it.immune_both  = r12v;
        it.infected_one = i1v;
        it.infected_two = i2v;
        state_queue.push_back(it);
    endtask

    task automatic push_random(int n);
        logic [30:0] f[6];
        for (int j = 0; j < n; j++) begin
            for (int q = 0; q < 6; q++) begin
                if ($urandom_range(9) == 0) f[q] = 31'($urandom);
                else f[q] = 31'($urandom_range(0, 32'h40000000));
            end
            push_state(16'($urandom), f[0], f[1], f[2], f[3], f[4], f[5]);
        end
    endtask

    task automatic random_setting(bit wild);
        if (wild) begin
            set_all($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 131071),
                    $urandom_range(0, 131071), $urandom, $urandom);
        end else begin
            set_all($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 28),
                    $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 27),
                    $urandom_range(0, 65536), $urandom_range(0, 65536),
                    $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
        end
    endtask

    initial begin
        logic [30:0] fmax;
        fmax          = '1;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_ready       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        hold_left     = 0;
        in_taken      = 1'b0;
        errors        = 0;
        cycles        = 0;
        for (int r = 0; r < 8; r++) regs_model[r] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values, then a realistic setting with phase extremes
        push_state(16'd0, 31'h40000000, 0, 0, 0, 31'h100000, 0);
        wait_idle();
        set_all(32'd20971, 32'd104857600, 32'd52428800, 32'd52428800,
                32'd13107, 32'd32768, 32'd1024, 32'd2048);
        reg_write(UNUSED_INDEX, 32'hFFFFFFFF);
        reg_write(TOP_INDEX, 32'hFFFFFFFF);
        push_state(16'd0, 31'h30000000, 31'h1000000, 31'h2000000, 31'h100000,
                   31'h400000, 31'h300000);
        push_state(16'd16384, 31'h30000000, 31'h1000000, 31'h2000000, 31'h100000,
                   31'h400000, 31'h300000);
        push_state(16'd32768, 31'h30000000, 31'h1000000, 31'h2000000, 31'h100000,
                   31'h400000, 31'h300000);
        push_state(16'd49152, 31'h30000000, 31'h1000000, 31'h2000000, 31'h100000,
                   31'h400000, 31'h300000);
        push_state(16'hFFFF, 31'h40000000, 0, 0, 0, 0, 0);
        push_state(16'd63, 0, 0, 0, 0, 0, 0);
        push_state(16'd64, fmax, fmax, fmax, fmax, fmax, fmax);
        wait_idle();
        // everything at its top: share and amplitude saturate, flows cap
        set_all('1, '1, '1, '1, 32'h1FFFF, 32'h1FFFF, '1, '1);
        push_state(16'd0, fmax, fmax, fmax, fmax, fmax, fmax);
        push_state(16'd32768, fmax, fmax, fmax, fmax, fmax, fmax);
        push_state(16'd8192, 0, 0, 0, 0, 0, 0);
        push_state(16'hFFFF, fmax, 0, fmax, 0, fmax, 0);
        wait_idle();
        set_all(32'd0, 32'd1 << 20, 32'd1 << 20, 32'd0, 32'd65536, 32'd65536, 32'd0, 32'd0);
        push_state(16'd32768, 31'h40000000, 31'h40000000, 31'h40000000, 0,
                   31'h40000000, 31'h40000000);
        push_state(16'd0, 31'h40000000, 31'h20000000, 31'h20000000, 31'h1,
                   31'h40000000, 31'h40000000);
        wait_idle();

        // random phases
        send_idle_pct = 25;
        recv_idle_pct = 49;
        random_setting(1'b0);
        push_random(120);
        @(posedge i_clk);
        hold_request = 300;
        wait_idle();
        random_setting(1'b1);
        push_random(80);
        wait_idle();
        send_idle_pct = 49;
        recv_idle_pct = 25;
        random_setting(1'b0);
        push_random(150);
        wait_idle();
        random_setting(1'b1);
        push_random(80);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_setting(1'b0);
        push_random(170);
        wait_idle();
        random_setting(1'b0);
        push_random(150);
        @(posedge i_clk);
        hold_request = 200;
        wait_idle();

        if (errors == 0) begin
            $display("two_strain_epidemic_rhs_core verification clean");
        end else begin
            $display("two_strain_epidemic_rhs_core verification failed");
        end
        $finish;
    end

endmodule
